// File: sv/dpd_pkg.sv
// Shared types, codes and the checksum digit helper for the debug packet deframer.
// Has no dependencies; used by dpd_parser and debug_packet_deframer.
package dpd_pkg;

    localparam logic [7:0] CHAR_START = 8'h24;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd128;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;
    localparam logic [1:0] KIND_LONG = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DATA = 4'b0010,
        PH_CK1  = 4'b0100,
        PH_CK2  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] payload_length;
    } result_t;

    // A digit matches a nibble when the character equals the character that
    // its letter-case class would decode to that nibble.
    function automatic logic hex_match(input logic [7:0] c, input logic [3:0] nib);
        logic [7:0] expect_char;
        if (!c[6]) begin
            expect_char = {4'd0, nib} + 8'd48;
        end else if (c[5]) begin
            expect_char = {4'd0, nib} + 8'd87;
        end else begin
            expect_char = {4'd0, nib} + 8'd55;
        end
        return c == expect_char;
    endfunction

endpackage

// File: sv/dpd_parser.sv
// Framing state machine: phase, running checksum and byte count, plus the result
// that each received character produces. Depends on dpd_pkg.
module dpd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_char,
    input  logic [7:0]       max_payload,
    output dpd_pkg::result_t result
);
    import dpd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] count_reg, count_next;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        result     = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_char == CHAR_START) begin
                    sum_next   = 8'd0;
                    count_next = 8'd0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                if (rx_char == CHAR_HASH) begin
                    phase_next = PH_CK1;
                end else if (count_reg >= max_payload) begin
                    phase_next            = PH_IDLE;
                    result.valid          = 1'b1;
                    result.kind           = KIND_LONG;
                    result.payload_length = count_reg;
                end else begin
                    sum_next              = sum_reg + rx_char;
                    count_next            = count_reg + 8'd1;
                    result.valid          = 1'b1;
                    result.kind           = KIND_BYTE;
                    result.data_byte      = rx_char;
                    result.first_byte     = (count_reg == 8'd0);
                    result.payload_length = count_reg + 8'd1;
                end
            end
            PH_CK1: begin
                if (!hex_match(rx_char, sum_reg[7:4])) begin
                    phase_next            = PH_IDLE;
                    result.valid          = 1'b1;
                    result.kind           = KIND_BAD;
                    result.payload_length = count_reg;
                end else begin
                    phase_next = PH_CK2;
                end
            end
            PH_CK2: begin
                phase_next            = PH_IDLE;
                result.valid          = 1'b1;
                result.kind           = hex_match(rx_char, sum_reg[3:0]) ?
                                        KIND_GOOD : KIND_BAD;
                result.payload_length = count_reg;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sum_reg   <= 8'd0;
            count_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/debug_packet_deframer.sv
// Top level of the debug packet deframer: APB register, parser and result register.
// Depends on dpd_pkg and dpd_parser.
// The block takes one received character per cycle unless stalled, and reports each
// payload byte of a $payload#hh packet as it arrives, followed by one verdict
// (good, bad checksum or too long) with the payload length. A request is accepted
// in every cycle unless a finished result is still waiting to be taken; the
// character is decoded in the cycle it is accepted and its result appears on
// the m_ side in the next cycle, from a single result register. The max_payload
// register sits at byte address 0 and should be written only while idle.
module debug_packet_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_char,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [7:0]                     m_data_byte,
    output logic                           m_first_byte,
    output logic [7:0]                     m_payload_length
);
    import dpd_pkg::*;

    logic [7:0] max_payload_reg;
    logic       accept;
    result_t    result;
    logic       m_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;
    logic       first_reg;
    logic [7:0] length_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_MAX_PAYLOAD) ? {24'd0, max_payload_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && paddr[APB_ADDR_W-1] == REG_MAX_PAYLOAD) begin
            max_payload_reg <= pwdata[7:0];
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    dpd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_char     (s_rx_char),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= result.valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && result.valid) begin
            kind_reg   <= result.kind;
            data_reg   <= result.data_byte;
            first_reg  <= result.first_byte;
            length_reg <= result.payload_length;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_data_byte      = data_reg;
    assign m_first_byte     = first_reg;
    assign m_payload_length = length_reg;

endmodule

// File: sv/dpd_checker.sv
// Port-level checker for the debug packet deframer and its bind to the top level.
// Depends on dpd_pkg and debug_packet_deframer.
module dpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_data_byte,
    input logic       m_first_byte,
    input logic [7:0] m_payload_length
);
    import dpd_pkg::*;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_payload_length))
        else $error("A stalled result changed.");

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("The input was stalled without a waiting result.");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_BYTE |-> m_data_byte == 8'd0 && !m_first_byte)
        else $error("A verdict carried payload data.");

    a_first_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_first_byte |-> m_kind == KIND_BYTE && m_payload_length == 8'd1)
        else $error("The first payload byte had a wrong length.");

    a_byte_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BYTE |-> m_payload_length != 8'd0)
        else $error("A payload byte reported a zero length.");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kind           (m_kind),
    .m_data_byte      (m_data_byte),
    .m_first_byte     (m_first_byte),
    .m_payload_length (m_payload_length)
);

// File: tb/sv/tb_debug_packet_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for debug_packet_deframer: a scoreboard class predicts each
// request's result and compares it with the m_ side. Depends on dpd_pkg and the RTL.
module tb_debug_packet_deframer;
    import dpd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_FIRST  = 1;
    localparam int FLAW_SECOND = 2;
    localparam logic [7:0] ZERO_CHAR    = 8'h30;
    localparam logic [7:0] LOWER_A_CHAR = 8'h61;
    localparam logic [7:0] UPPER_A_CHAR = 8'h41;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] payload_length;
    } deframer_result_t;

    class deframer_scoreboard;
        phase_t           state;
        logic [7:0]       max_len;
        logic [7:0]       sum;
        logic [7:0]       count;
        deframer_result_t expected_q[$];
        int               errors;
        int               n_chars, n_bytes, n_good, n_bad, n_long;

        function new();
            state   = PH_IDLE;
            max_len = MAX_PAYLOAD_RESET;
            sum     = 8'd0;
            count   = 8'd0;
        endfunction

        function void set_max_payload(input logic [7:0] value);
            max_len = value;
        endfunction

        // Decodes a checksum digit by its letter-case class; the value may fall outside 0..15.
        static function int digit_value(input logic [7:0] c);
            if (!c[6]) begin
                return int'(c) - int'(ZERO_CHAR);
            end else if (c[5]) begin
                return int'(c) - int'(LOWER_A_CHAR) + 10;
            end
            return int'(c) - int'(UPPER_A_CHAR) + 10;
        endfunction

        function void note_char(input logic [7:0] c);
            deframer_result_t r;
            bit               produce;
            r       = '0;
            produce = 1'b0;
            n_chars++;
            case (state)
                PH_IDLE: begin
                    if (c == CHAR_START) begin
                        sum   = 8'd0;
                        count = 8'd0;
                        state = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (c == CHAR_HASH) begin
                        state = PH_CK1;
                    end else if (count >= max_len) begin
                        state            = PH_IDLE;
                        r.kind           = KIND_LONG;
                        r.payload_length = count;
                        produce          = 1'b1;
                    end else begin
                        sum              = sum + c;
                        r.kind           = KIND_BYTE;
                        r.data_byte      = c;
                        r.first_byte     = (count == 8'd0);
                        count            = count + 8'd1;
                        r.payload_length = count;
                        produce          = 1'b1;
                    end
                end
                PH_CK1: begin
                    if (digit_value(c) != int'(sum[7:4])) begin
                        state            = PH_IDLE;
                        r.kind           = KIND_BAD;
                        r.payload_length = count;
                        produce          = 1'b1;
                    end else begin
                        state = PH_CK2;
                    end
                end
                default: begin
                    state            = PH_IDLE;
                    r.kind           = (digit_value(c) == int'(sum[3:0])) ? KIND_GOOD : KIND_BAD;
                    r.payload_length = count;
                    produce          = 1'b1;
                end
            endcase
            if (produce) begin
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(input deframer_result_t got);
            deframer_result_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d data=%02h first=%0b len=%0d",
                         $time, got.kind, got.data_byte, got.first_byte, got.payload_length);
                return;
            end
            exp = expected_q.pop_front();
            if (got.kind != exp.kind || got.data_byte != exp.data_byte ||
                got.first_byte != exp.first_byte ||
                got.payload_length != exp.payload_length) begin
                errors++;
                $display("%0t: result mismatch, expected kind=%0d data=%02h first=%0b len=%0d",
                         $time, exp.kind, exp.data_byte, exp.first_byte, exp.payload_length);
                $display("%0t:                  actual kind=%0d data=%02h first=%0b len=%0d",
                         $time, got.kind, got.data_byte, got.first_byte, got.payload_length);
            end
            case (got.kind)
                KIND_BYTE: n_bytes++;
                KIND_GOOD: n_good++;
                KIND_BAD:  n_bad++;
                default:   n_long++;
            endcase
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_char = 8'd0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic [1:0]            m_kind;
    logic [7:0]            m_data_byte;
    logic                  m_first_byte;
    logic [7:0]            m_payload_length;

    deframer_scoreboard sb;
    logic [7:0]         tx_chars[$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 backpressure_cycles = 0;
    int                 quiet_cycles = 0;
    int                 n_settings = 0;

    debug_packet_deframer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_char        (s_rx_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_first_byte     (m_first_byte),
        .m_payload_length (m_payload_length)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_kind, m_data_byte, m_first_byte, m_payload_length});
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (backpressure_cycles > 0) begin
            m_ready <= 1'b0;
            backpressure_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes max_payload and reads it back in one APB sequence.
    task automatic program_max_payload(input logic [7:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr = APB_ADDR_W'(4 * REG_MAX_PAYLOAD);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_max_payload(value);
        n_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] != value) begin
            sb.errors++;
            $display("%0t: max_payload readback mismatch, expected %0d, actual %0d",
                     $time, value, prdata[7:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_char <= c;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_char(c);
    endtask

    task automatic send_all();
        while (tx_chars.size() > 0) send_char(tx_chars.pop_front());
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        if (nib == 4'd9) begin
            case ($urandom_range(2))
                0:       return ZERO_CHAR + 8'd9;
                1:       return UPPER_A_CHAR - 8'd1;
                default: return LOWER_A_CHAR - 8'd1;
            endcase
        end else if (nib < 4'd10) begin
            return ZERO_CHAR + nib;
        end else if ($urandom_range(1) != 0) begin
            return LOWER_A_CHAR + nib - 8'd10;
        end
        return UPPER_A_CHAR + nib - 8'd10;
    endfunction

    function automatic logic [7:0] wrong_digit(input logic [3:0] nib);
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (deframer_scoreboard::digit_value(c) == int'(nib));
        return c;
    endfunction

    function automatic void add_packet(input int unsigned len, input int flaw);
        logic [7:0] sum;
        logic [7:0] c;
        sum = 8'd0;
        tx_chars.push_back(CHAR_START);
        repeat (len) begin
            do c = 8'($urandom_range(255)); while (c == CHAR_HASH);
            sum = sum + c;
            tx_chars.push_back(c);
        end
        tx_chars.push_back(CHAR_HASH);
        case (flaw)
            FLAW_FIRST: begin
                tx_chars.push_back(wrong_digit(sum[7:4]));
                tx_chars.push_back(8'($urandom_range(255)));
            end
            FLAW_SECOND: begin
                tx_chars.push_back(digit_char(sum[7:4]));
                tx_chars.push_back(wrong_digit(sum[3:0]));
            end
            default: begin
                tx_chars.push_back(digit_char(sum[7:4]));
                tx_chars.push_back(digit_char(sum[3:0]));
            end
        endcase
    endfunction

    function automatic void add_random_packet(input int unsigned limit);
        int unsigned mode, long_pct, cap;
        int          flaw;
        mode     = $urandom_range(99);
        long_pct = (limit <= 16) ? 10 : 2;
        case ($urandom_range(9))
            0:       flaw = FLAW_FIRST;
            1:       flaw = FLAW_SECOND;
            default: flaw = FLAW_NONE;
        endcase
        cap = (limit < 12) ? limit : 12;
        if (mode < 8) begin
            repeat ($urandom_range(1, 6)) tx_chars.push_back(8'($urandom_range(255)));
        end else if (mode < 8 + long_pct) begin
            add_packet(limit + $urandom_range(1, 3), flaw);
        end else if (mode < 11 + long_pct) begin
            add_packet(limit, flaw);
        end else begin
            add_packet($urandom_range(0, cap), flaw);
        end
    endfunction

    task automatic run_phase(input logic [7:0] limit, input int idle_pct, input int stall_pct,
                             input int items, input int hold, input bit with_extremes);
        program_max_payload(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_extremes) begin
            add_packet(limit, FLAW_NONE);
            add_packet(limit + 2, FLAW_NONE);
        end
        while (tx_chars.size() < items) add_random_packet(limit);
        backpressure_cycles = hold;
        send_all();
        drain();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Junk while idle, then packets covering both letter cases, the digit-nine
        // aliases, a dollar inside the payload, a bad first digit and a bad second digit.
        tx_chars = {8'h00, 8'hFF, CHAR_HASH,
                    CHAR_START, 8'hFF, CHAR_START, 8'h00, 8'hB9, CHAR_HASH, 8'h64, 8'h43,
                    CHAR_START, 8'h99, CHAR_HASH, 8'h40, 8'h60,
                    CHAR_START, 8'h61, CHAR_HASH, 8'h78, 8'h30,
                    CHAR_START, CHAR_HASH, 8'h30, 8'h31};
        send_all();
        drain();

        program_max_payload(8'd1);
        tx_chars = {CHAR_START, 8'h6B, 8'h6D,
                    CHAR_START, 8'h6B, CHAR_HASH, 8'h36, 8'h42};
        send_all();
        drain();

        program_max_payload(8'd0);
        tx_chars = {CHAR_START, 8'h71, CHAR_HASH};
        send_all();
        drain();

        run_phase(8'd255, 0, 0, 500, 0, 1'b1);
        run_phase(8'($urandom_range(1, 255)), 77, 0, 400, 0, 1'b0);
        run_phase(8'd6, 0, 77, 400, 0, 1'b1);
        run_phase(8'd128, 30, 30, 400, 0, 1'b0);
        run_phase(8'($urandom_range(1, 40)), 0, 0, 300, 300, 1'b0);

        repeat (8) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
        end
        $display("Sent %0d characters; saw %0d payload bytes, %0d good, %0d bad-checksum,",
                 sb.n_chars, sb.n_bytes, sb.n_good, sb.n_bad);
        $display("%0d oversize, over %0d max_payload settings with idle, stall and long stalls.",
                 sb.n_long, n_settings);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/dpd_pkg.sv
sv/dpd_parser.sv
sv/debug_packet_deframer.sv
sv/dpd_checker.sv
tb/sv/tb_debug_packet_deframer.sv
